@@ src/vrhc_pkg.sv @@
// Shared widths and register indexes for the heat colormap pipeline.
package vrhc_pkg;

  localparam int unsigned SAMPLE_WIDTH  = 32;
  localparam int unsigned FRACTION_BITS = 16;

  localparam int unsigned CFG_W   = 32;
  localparam int unsigned PADDR_W = 3;

  // clamped span and distance from the upper bound, one guard bit
  localparam int unsigned DEN_W      = SAMPLE_WIDTH + 1;
  // 5 * num needs three more bits; hue / 60 lies in [0, 5 * 2^F]
  localparam int unsigned PROD_EXTRA = 3;
  localparam int unsigned PROD_W     = DEN_W + PROD_EXTRA;
  localparam int unsigned QUOT_W     = FRACTION_BITS + PROD_EXTRA;
  localparam int unsigned SECT_W     = QUOT_W - FRACTION_BITS;

  localparam logic [0:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [0:0] REG_RANGE_HIGH = 1'b1;

endpackage

@@ src/vrhc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module vrhc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vrhc_pkg::DEN_W-1:0]    den_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vrhc_pkg::PROD_W-1:0]   prod_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vrhc_pkg::QUOT_W-1:0]   quot_o
);
  import vrhc_pkg::*;

  localparam int unsigned NST = QUOT_W;

  logic [DEN_W-1:0]  stg_rem  [NST];
  logic [QUOT_W-1:0] stg_bits [NST];
  logic [QUOT_W-1:0] stg_quot [NST];
  logic              stg_vld  [NST];
  logic              stg_rdy  [NST];

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic [DEN_W-1:0]  rem_s;
    logic [QUOT_W-1:0] bits_s;
    logic [QUOT_W-1:0] quot_s;
    logic              vld_s;
    logic              nxt_rdy;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic              vld_q;
    logic [DEN_W-1:0]  rem_q;
    logic [QUOT_W-1:0] bits_q;
    logic [QUOT_W-1:0] quot_q;

    if (i == 0) begin : g_first
      assign rem_s  = prod_i[PROD_W-1:PROD_EXTRA];
      assign bits_s = {prod_i[PROD_EXTRA-1:0], {FRACTION_BITS{1'b0}}};
      assign quot_s = '0;
      assign vld_s  = in_valid_i;
    end else begin : g_next
      assign rem_s  = stg_rem[i-1];
      assign bits_s = stg_bits[i-1];
      assign quot_s = stg_quot[i-1];
      assign vld_s  = stg_vld[i-1];
    end

    if (i == NST - 1) begin : g_last
      assign nxt_rdy = out_ready_i;
    end else begin : g_mid
      assign nxt_rdy = stg_rdy[i+1];
    end

    assign trial = {rem_s, bits_s[QUOT_W-1]};
    assign ge    = trial >= {1'b0, den_i};

    assign stg_rdy[i] = !vld_q || nxt_rdy;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (stg_rdy[i]) begin
        vld_q <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[i] && vld_s) begin
        rem_q  <= ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
        bits_q <= {bits_s[QUOT_W-2:0], 1'b0};
        quot_q <= {quot_s[QUOT_W-2:0], ge};
      end
    end

    assign stg_vld[i]  = vld_q;
    assign stg_rem[i]  = rem_q;
    assign stg_bits[i] = bits_q;
    assign stg_quot[i] = quot_q;
  end

  assign in_ready_o  = stg_rdy[0];
  assign out_valid_o = stg_vld[NST-1];
  assign quot_o      = stg_quot[NST-1];

endmodule

@@ src/value_to_rgb_heat_colormap.sv @@
// Heat colormap top level: APB range registers, clamp, divide and HSV sector pipeline.
// Pipeline: 3 front stages, 19 divider stages and 1 output register between
//   input transfer and output tvalid, one bit of hue/60 per divider stage.
// Throughput: one transfer per cycle; stalls fill bubbles before blocking input.
// Reset: range_low = 0, range_high = 65535, pipeline emptied; a register write
//   reaches samples through the registered bounds and span.
module value_to_rgb_heat_colormap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vrhc_pkg::PADDR_W-1:0]   paddr,
  input  logic [vrhc_pkg::CFG_W-1:0]     pwdata,
  output logic [vrhc_pkg::CFG_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // [31:0] sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import vrhc_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;

  // sector + 1 as taken from the top bits of hue / 60
  localparam logic [SECT_W-1:0] SECT_WRAP = SECT_W'(0);
  localparam logic [SECT_W-1:0] SECT_RY   = SECT_W'(1);
  localparam logic [SECT_W-1:0] SECT_YG   = SECT_W'(2);
  localparam logic [SECT_W-1:0] SECT_GC   = SECT_W'(3);
  localparam logic [SECT_W-1:0] SECT_CB   = SECT_W'(4);
  localparam logic [SECT_W-1:0] SECT_BM   = SECT_W'(5);

  // configuration
  logic [CFG_W-1:0] lo_cfg_q, hi_cfg_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RANGE_HIGH) ? hi_cfg_q : lo_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_cfg_q <= '0;
      hi_cfg_q <= CFG_W'(65535);
    end else if (wr_en) begin
      if (paddr[2] == REG_RANGE_HIGH) begin
        hi_cfg_q <= pwdata;
      end else begin
        lo_cfg_q <= pwdata;
      end
    end
  end

  // effective bounds and span
  logic signed [SW:0] lo_s, hi_s, hie_d;
  logic signed [SW:0] lo_q, hie_q;
  logic [DEN_W-1:0]   den_q;

  assign lo_s  = {lo_cfg_q[SW-1], lo_cfg_q[SW-1:0]};
  assign hi_s  = {hi_cfg_q[SW-1], hi_cfg_q[SW-1:0]};
  assign hie_d = (hi_s <= lo_s) ? lo_s + (SW+1)'(1) : hi_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hie_q <= (SW+1)'(65535);
      den_q <= DEN_W'(65535);
    end else begin
      lo_q  <= lo_s;
      hie_q <= hie_d;
      den_q <= DEN_W'(hie_d - lo_s);
    end
  end

  // front stages: clamp, distance from top, times five
  logic               p1_vld_q, p2_vld_q, p3_vld_q;
  logic               p1_rdy, p2_rdy, p3_rdy;
  logic signed [SW:0] v_s;
  logic signed [SW:0] vc_q;
  logic [DEN_W-1:0]   num_q;
  logic [PROD_W-1:0]  prod_q;
  logic               div_in_rdy, div_vld, out_rdy;
  logic [QUOT_W-1:0]  div_quot;

  assign v_s = {s_axis_tdata[SW-1], s_axis_tdata[SW-1:0]};

  assign p3_rdy        = !p3_vld_q || div_in_rdy;
  assign p2_rdy        = !p2_vld_q || p3_rdy;
  assign p1_rdy        = !p1_vld_q || p2_rdy;
  assign s_axis_tready = p1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else begin
      if (p1_rdy) begin
        p1_vld_q <= s_axis_tvalid;
      end
      if (p2_rdy) begin
        p2_vld_q <= p1_vld_q;
      end
      if (p3_rdy) begin
        p3_vld_q <= p2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && s_axis_tvalid) begin
      if (v_s < lo_q) begin
        vc_q <= lo_q;
      end else if (v_s > hie_q) begin
        vc_q <= hie_q;
      end else begin
        vc_q <= v_s;
      end
    end
    if (p2_rdy && p1_vld_q) begin
      num_q <= DEN_W'(hie_q - vc_q);
    end
    if (p3_rdy && p2_vld_q) begin
      prod_q <= {1'b0, num_q, 2'b00} + {{PROD_EXTRA{1'b0}}, num_q};
    end
  end

  vrhc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .den_i       (den_q),
    .in_valid_i  (p3_vld_q),
    .in_ready_o  (div_in_rdy),
    .prod_i      (prod_q),
    .out_valid_o (div_vld),
    .out_ready_i (out_rdy),
    .quot_o      (div_quot)
  );

  // sector select and channel scaling
  logic [SECT_W-1:0]          sect;
  logic [FRACTION_BITS-1:0]   frac;
  logic [FRACTION_BITS:0]     qv;
  logic [FRACTION_BITS+7:0]   t_mul;
  logic [FRACTION_BITS+8:0]   q_mul;
  logic [7:0]                 t_ch, q_ch;
  logic [7:0]                 red_d, green_d, blue_d;
  logic                       out_vld_q;
  logic [23:0]                tdata_q;

  assign sect  = div_quot[QUOT_W-1:FRACTION_BITS];
  assign frac  = div_quot[FRACTION_BITS-1:0];
  assign qv    = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, frac};
  assign t_mul = {frac, 8'h00} - {8'h00, frac};
  assign q_mul = {qv, 8'h00} - {8'h00, qv};
  assign t_ch  = t_mul[FRACTION_BITS+7:FRACTION_BITS];
  assign q_ch  = q_mul[FRACTION_BITS+7:FRACTION_BITS];

  always_comb begin
    unique case (sect)
      SECT_RY: begin red_d = 8'hFF; green_d = t_ch;  blue_d = 8'h00; end
      SECT_YG: begin red_d = q_ch;  green_d = 8'hFF; blue_d = 8'h00; end
      SECT_GC: begin red_d = 8'h00; green_d = 8'hFF; blue_d = t_ch;  end
      SECT_CB: begin red_d = 8'h00; green_d = q_ch;  blue_d = 8'hFF; end
      SECT_BM: begin red_d = t_ch;  green_d = 8'h00; blue_d = 8'hFF; end
      SECT_WRAP: begin red_d = 8'hFF; green_d = 8'h00; blue_d = q_ch; end
      default: begin red_d = 8'hFF; green_d = 8'h00; blue_d = q_ch; end
    endcase
  end

  assign out_rdy = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_vld) begin
      tdata_q <= {blue_d, green_d, red_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tdata_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    den_q != '0)
    else $error("span register is zero");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input blocked while output register is empty");

  a_color_full_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[7:0] == 8'hFF || m_axis_tdata[15:8] == 8'hFF ||
       m_axis_tdata[23:16] == 8'hFF) &&
      (m_axis_tdata[7:0] == 8'h00 || m_axis_tdata[15:8] == 8'h00 ||
       m_axis_tdata[23:16] == 8'h00))
    else $error("color lacks a full or an empty channel");

endmodule
